// ----- hw/rtl/hsv2rgb_pkg.sv -----
// Shared types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int HUE_W       = 15;
  localparam int FRAC_IN_W   = 16;
  localparam int CHAN_W      = 8;
  localparam int POS_W       = 12;
  localparam int HUE_SECTORS = 6;
  localparam int HUE_SECTOR  = 3840;

  localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

endpackage

// ----- hw/rtl/hsv2rgb_front.sv -----
// Input stage: hue wrap, sector split and clamping of saturation and value.
module hsv2rgb_front #(
  parameter int FRACTION_BITS = 15
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue,
  input  logic [hsv2rgb_pkg::FRAC_IN_W-1:0]   saturation,
  input  logic [hsv2rgb_pkg::FRAC_IN_W-1:0]   brightness,
  output hsv2rgb_pkg::sector_t                sector,
  output logic [hsv2rgb_pkg::POS_W-1:0]       pos,
  output logic [hsv2rgb_pkg::POS_W-1:0]       npos,
  output logic [FRACTION_BITS:0]              sat,
  output logic [FRACTION_BITS:0]              val,
  output logic [FRACTION_BITS:0]              one_minus_sat,
  output logic                                sat_zero
);
  import hsv2rgb_pkg::*;

  localparam int FW = FRACTION_BITS + 1;
  localparam int CW = (FW > FRAC_IN_W) ? FW : FRAC_IN_W;
  localparam logic [FW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [HUE_W-1:0] hue_w;
  logic [HUE_W-1:0] base;
  logic [2:0]       sec;
  logic [CW-1:0]    sat_ext;
  logic [CW-1:0]    val_ext;
  logic [FW-1:0]    sat_cl;
  logic [FW-1:0]    val_cl;
  logic [POS_W-1:0] pos_c;

  always_comb begin
    // A full turn or more reads as hue zero.
    hue_w = (hue >= HUE_FULL) ? '0 : hue;
    sec   = 3'd0;
    base  = '0;
    for (int k = 1; k < HUE_SECTORS; k++) begin
      if (hue_w >= HUE_W'(k * HUE_SECTOR)) begin
        sec  = 3'(k);
        base = HUE_W'(k * HUE_SECTOR);
      end
    end
    pos_c   = POS_W'(hue_w - base);
    sat_ext = CW'(saturation);
    val_ext = CW'(brightness);
    sat_cl  = (sat_ext > CW'(ONE)) ? ONE : FW'(sat_ext);
    val_cl  = (val_ext > CW'(ONE)) ? ONE : FW'(val_ext);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector        <= sector_t'(sec);
      pos           <= pos_c;
      npos          <= POS_W'(HUE_SECTOR) - pos_c;
      sat           <= sat_cl;
      val           <= val_cl;
      one_minus_sat <= ONE - sat_cl;
      sat_zero      <= (sat_cl == '0);
    end
  end

endmodule

// ----- hw/rtl/hsv2rgb_div.sv -----
// Two-stage divide by 3840: shift by 256, then reciprocal multiply by 1/15 with correction.
module hsv2rgb_div #(
  parameter int DIVIDEND_W = 28
) (
  input  logic                   clk,
  input  logic [1:0]             en,
  input  logic [DIVIDEND_W-1:0]  dividend,
  output logic [DIVIDEND_W-12:0] quotient
);
  import hsv2rgb_pkg::*;

  localparam int YW = DIVIDEND_W - 8;
  localparam int K  = YW + 4;
  localparam int MW = YW + 1;
  localparam int QW = YW - 3;
  localparam int PW = YW + MW;

  localparam logic [K:0]    TWO_K      = {1'b1, {K{1'b0}}};
  localparam logic [K:0]    RECIP_FULL = TWO_K / (K+1)'(15);
  localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];

  logic [YW-1:0] y;
  logic [PW-1:0] y_ext;
  logic [PW-1:0] recip_ext;
  logic [YW-1:0] y_a;
  logic [PW-1:0] prod_a;
  logic [QW-1:0] q0;
  logic [YW:0]   times15;
  logic [YW:0]   rem;
  logic [QW-1:0] q_fix;

  assign y         = dividend[DIVIDEND_W-1:8];
  assign y_ext     = PW'(y);
  assign recip_ext = PW'(RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y_a    <= y;
      prod_a <= y_ext * recip_ext;
    end
  end

  // Estimate is the true quotient or one short; fix it from the remainder.
  always_comb begin
    q0      = prod_a[K +: QW];
    times15 = {q0, 4'b0000} - (YW+1)'(q0);
    rem     = (YW+1)'(y_a) - times15;
    q_fix   = (rem >= (YW+1)'(15)) ? q0 + QW'(1) : q0;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      quotient <= q_fix;
    end
  end

endmodule

// ----- hw/rtl/hsv_to_rgb_converter_core.sv -----
// Top level of the pipelined HSV to RGB pixel converter.
//
//  channel | direction | word layout (lowest bit first)                 | handshake
//  --------+-----------+------------------------------------------------+----------------
//  s_*     | in        | hue[14:0], saturation[30:15], brightness[46:31] | tvalid/tready
//  m_*     | out       | red[7:0], green[15:8], blue[23:16]              | tvalid/tready
//
// Seven register stages: input decode, s*pos products, reciprocal product,
// quotient correction, q/t/p products, sector select, channel scale. One
// pixel enters per clock while the output is not stalled; the depth is set by
// the two multiply levels and the divide by 3840 between them.
// Reset clears only the stage valid bits; payload registers are left as is.
// Each stage holds while its successor is full and stalled; an empty stage
// keeps taking words, so bubbles close up behind a stalled output.
module hsv_to_rgb_converter_core #(
  parameter int FRACTION_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // hue[14:0], saturation[30:15], brightness[46:31], pad[47]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);
  import hsv2rgb_pkg::*;

  localparam int NSTAGE = 7;
  localparam int FW     = FRACTION_BITS + 1;
  localparam int PW     = FW + POS_W;
  localparam int WW     = 2 * FW;
  localparam int CHW    = FW + CHAN_W;
  localparam logic [FW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // Stage control
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] en;

  always_comb begin
    en[NSTAGE] = !vld[NSTAGE] || m_tready;
    for (int i = NSTAGE - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int i = 2; i <= NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[NSTAGE];

  // Stage 1: decode and clamp
  sector_t          sector1;
  logic [POS_W-1:0] pos1;
  logic [POS_W-1:0] npos1;
  logic [FW-1:0]    sat1;
  logic [FW-1:0]    val1;
  logic [FW-1:0]    oms1;
  logic             szero1;

  hsv2rgb_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk           (clk),
    .en            (en[1]),
    .hue           (s_tdata[14:0]),
    .saturation    (s_tdata[30:15]),
    .brightness    (s_tdata[46:31]),
    .sector        (sector1),
    .pos           (pos1),
    .npos          (npos1),
    .sat           (sat1),
    .val           (val1),
    .one_minus_sat (oms1),
    .sat_zero      (szero1)
  );

  // Stage 2: s*pos and s*(3840-pos)
  logic [PW-1:0] sat_ext;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] npos_ext;
  logic [PW-1:0] psf2;
  logic [PW-1:0] psg2;
  sector_t       sector2;
  logic [FW-1:0] val2;
  logic [FW-1:0] oms2;
  logic          szero2;

  assign sat_ext  = PW'(sat1);
  assign pos_ext  = PW'(pos1);
  assign npos_ext = PW'(npos1);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      psf2    <= sat_ext * pos_ext;
      psg2    <= sat_ext * npos_ext;
      sector2 <= sector1;
      val2    <= val1;
      oms2    <= oms1;
      szero2  <= szero1;
    end
  end

  // Stages 3 and 4: divide both products by 3840
  logic [PW-12:0] sf_q;
  logic [PW-12:0] sg_q;
  sector_t        sector3;
  sector_t        sector4;
  logic [FW-1:0]  val3;
  logic [FW-1:0]  val4;
  logic [FW-1:0]  oms3;
  logic [FW-1:0]  oms4;
  logic           szero3;
  logic           szero4;

  hsv2rgb_div #(
    .DIVIDEND_W (PW)
  ) u_div_sf (
    .clk      (clk),
    .en       ({en[4], en[3]}),
    .dividend (psf2),
    .quotient (sf_q)
  );

  hsv2rgb_div #(
    .DIVIDEND_W (PW)
  ) u_div_sg (
    .clk      (clk),
    .en       ({en[4], en[3]}),
    .dividend (psg2),
    .quotient (sg_q)
  );

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sector3 <= sector2;
      val3    <= val2;
      oms3    <= oms2;
      szero3  <= szero2;
    end
    if (en[4]) begin
      sector4 <= sector3;
      val4    <= val3;
      oms4    <= oms3;
      szero4  <= szero3;
    end
  end

  // Stage 5: v*(1-sf), v*(1-sg), v*(1-s)
  logic [FW-1:0] sf4;
  logic [FW-1:0] sg4;
  logic [WW-1:0] val_w;
  logic [WW-1:0] qmul_w;
  logic [WW-1:0] tmul_w;
  logic [WW-1:0] pmul_w;
  logic [WW-1:0] qprod5;
  logic [WW-1:0] tprod5;
  logic [WW-1:0] pprod5;
  sector_t       sector5;
  logic [FW-1:0] val5;
  logic          szero5;

  assign sf4    = sf_q[FW-1:0];
  assign sg4    = sg_q[FW-1:0];
  assign val_w  = WW'(val4);
  assign qmul_w = WW'(ONE - sf4);
  assign tmul_w = WW'(ONE - sg4);
  assign pmul_w = WW'(oms4);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      qprod5  <= val_w * qmul_w;
      tprod5  <= val_w * tmul_w;
      pprod5  <= val_w * pmul_w;
      sector5 <= sector4;
      val5    <= val4;
      szero5  <= szero4;
    end
  end

  // Stage 6: pick the sector's component order
  logic [FW-1:0] p_c;
  logic [FW-1:0] q_c;
  logic [FW-1:0] t_c;
  logic [FW-1:0] r_sel;
  logic [FW-1:0] g_sel;
  logic [FW-1:0] b_sel;
  logic [FW-1:0] red6;
  logic [FW-1:0] green6;
  logic [FW-1:0] blue6;

  always_comb begin
    p_c = pprod5[FRACTION_BITS +: FW];
    q_c = qprod5[FRACTION_BITS +: FW];
    t_c = tprod5[FRACTION_BITS +: FW];
    case (sector5)
      SEC_RED: begin
        r_sel = val5; g_sel = t_c;  b_sel = p_c;
      end
      SEC_YELLOW: begin
        r_sel = q_c;  g_sel = val5; b_sel = p_c;
      end
      SEC_GREEN: begin
        r_sel = p_c;  g_sel = val5; b_sel = t_c;
      end
      SEC_CYAN: begin
        r_sel = p_c;  g_sel = q_c;  b_sel = val5;
      end
      SEC_BLUE: begin
        r_sel = t_c;  g_sel = p_c;  b_sel = val5;
      end
      default: begin
        r_sel = val5; g_sel = p_c;  b_sel = q_c;
      end
    endcase
    // Grey when there is no saturation.
    if (szero5) begin
      r_sel = val5;
      g_sel = val5;
      b_sel = val5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      red6   <= r_sel;
      green6 <= g_sel;
      blue6  <= b_sel;
    end
  end

  // Stage 7: scale by 255 and truncate into the output register
  logic [CHW-1:0]    r255;
  logic [CHW-1:0]    g255;
  logic [CHW-1:0]    b255;
  logic [CHAN_W-1:0] red7;
  logic [CHAN_W-1:0] green7;
  logic [CHAN_W-1:0] blue7;

  assign r255 = {red6,   {CHAN_W{1'b0}}} - CHW'(red6);
  assign g255 = {green6, {CHAN_W{1'b0}}} - CHW'(green6);
  assign b255 = {blue6,  {CHAN_W{1'b0}}} - CHW'(blue6);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      red7   <= r255[FRACTION_BITS +: CHAN_W];
      green7 <= g255[FRACTION_BITS +: CHAN_W];
      blue7  <= b255[FRACTION_BITS +: CHAN_W];
    end
  end

  assign m_tdata = {blue7, green7, red7};

endmodule

// ----- tb/tb_hsv_to_rgb_converter_core.sv -----
// Self-checking testbench for the streaming HSV to RGB pixel converter.
module tb_hsv_to_rgb_converter_core;
  import hsv2rgb_pkg::*;

  localparam int FRAC       = 15;
  localparam int N_CORNERS  = 22;
  localparam int N_RANDOM   = 1750;
  localparam int STALL_MAX  = 2000;
  localparam int DRAIN_WAIT = 20;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0]     hue;
    logic [FRAC_IN_W-1:0] sat;
    logic [FRAC_IN_W-1:0] val;
    bit                   typed;
    rgb_t                 rgb;
  } corner_t;

  // Corner pixels; rows with typed set carry an expected colour read straight off the maths.
  localparam corner_t CORNERS [N_CORNERS] = '{
    '{15'd0,     16'd0,     16'd0,     1'b1, '{8'd0,   8'd0,   8'd0}},
    '{15'd0,     16'd0,     16'd32768, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{15'd9000,  16'd0,     16'd65535, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{15'd32767, 16'd0,     16'd16384, 1'b1, '{8'd127, 8'd127, 8'd127}},
    '{15'd0,     16'd32768, 16'd32768, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{15'd3840,  16'd32768, 16'd32768, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{15'd7680,  16'd32768, 16'd32768, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{15'd11520, 16'd32768, 16'd32768, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{15'd15360, 16'd32768, 16'd32768, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{15'd19200, 16'd32768, 16'd32768, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{15'd23040, 16'd32768, 16'd32768, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{15'd32767, 16'd65535, 16'd65535, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{15'd5000,  16'd32768, 16'd0,     1'b1, '{8'd0,   8'd0,   8'd0}},
    '{15'd3839,  16'd32768, 16'd32768, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd23039, 16'd32768, 16'd32768, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd1920,  16'd16384, 16'd32768, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd5760,  16'd1,     16'd32768, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd9600,  16'd32767, 16'd1,     1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd13440, 16'd20000, 16'd30000, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd17280, 16'd32767, 16'd32767, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd21120, 16'd12345, 16'd23456, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd7681,  16'd40000, 16'd32769, 1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  rgb_t pending_rgb [$];
  bit   no_idle = 1'b0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  hsv_to_rgb_converter_core #(.FRACTION_BITS(FRAC)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CHAN_W-1:0] scale_channel(logic [63:0] frac);
    logic [63:0] scaled;
    scaled = (frac * 64'd255) >> FRAC;
    return scaled[CHAN_W-1:0];
  endfunction

  function automatic rgb_t hsv_to_rgb(logic [HUE_W-1:0] hue, logic [FRAC_IN_W-1:0] sat,
                                      logic [FRAC_IN_W-1:0] val);
    logic [63:0] one, s, v, h, pos, sf, sg, p, q, t, r, g, b;
    sector_t     sec;
    rgb_t        px;
    one = 64'd1 << FRAC;
    s   = (sat > one) ? one : 64'(sat);
    v   = (val > one) ? one : 64'(val);
    if (s == 0) begin
      px.red   = scale_channel(v);
      px.green = px.red;
      px.blue  = px.red;
      return px;
    end
    h   = (hue >= HUE_FULL) ? 64'd0 : 64'(hue);
    sec = sector_t'(h / HUE_SECTOR);
    pos = h % HUE_SECTOR;
    sf  = (s * pos) / HUE_SECTOR;
    sg  = (s * (HUE_SECTOR - pos)) / HUE_SECTOR;
    p   = (v * (one - s)) >> FRAC;
    q   = (v * (one - sf)) >> FRAC;
    t   = (v * (one - sg)) >> FRAC;
    case (sec)
      SEC_RED: begin
        r = v; g = t; b = p;
      end
      SEC_YELLOW: begin
        r = q; g = v; b = p;
      end
      SEC_GREEN: begin
        r = p; g = v; b = t;
      end
      SEC_CYAN: begin
        r = p; g = q; b = v;
      end
      SEC_BLUE: begin
        r = t; g = p; b = v;
      end
      default: begin
        r = v; g = p; b = q;
      end
    endcase
    px.red   = scale_channel(r);
    px.green = scale_channel(g);
    px.blue  = scale_channel(b);
    return px;
  endfunction

  // Offer one pixel, hold it until taken, then log what should come out.
  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [FRAC_IN_W-1:0] sat,
                            input logic [FRAC_IN_W-1:0] val, input bit typed,
                            input rgb_t typed_rgb);
    while (!no_idle && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, val, sat, hue};
    do @(posedge clk); while (!s_tready);
    pending_rgb.push_back(typed ? typed_rgb : hsv_to_rgb(hue, sat, val));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 19);
  end

  // Compare each delivered word with the oldest outstanding colour.
  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = rgb_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]});
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = pending_rgb.pop_front();
        if (got.red !== want.red) begin
          $display("%0t: red mismatch, expected %0d, actual %0d", $time, want.red, got.red);
          mismatches++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green mismatch, expected %0d, actual %0d",
                   $time, want.green, got.green);
          mismatches++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue mismatch, expected %0d, actual %0d", $time, want.blue, got.blue);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_MAX) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_MAX);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [HUE_W-1:0]     hue;
    logic [FRAC_IN_W-1:0] sat, val;
    int                   h;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_CORNERS; i++) begin
      send_pixel(CORNERS[i].hue, CORNERS[i].sat, CORNERS[i].val, CORNERS[i].typed,
                 CORNERS[i].rgb);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 800 && i < 1100);
      case ($urandom_range(9))
        7:       hue = HUE_W'($urandom_range(23040, 32767));
        8: begin
          // land on or beside a sector edge
          h = $urandom_range(0, 6) * HUE_SECTOR - 1 + $urandom_range(0, 2);
          hue = HUE_W'((h < 0) ? 0 : h);
        end
        9:       hue = HUE_W'($urandom_range(0, 32767));
        default: hue = HUE_W'($urandom_range(0, 23039));
      endcase
      case ($urandom_range(11))
        0:       sat = '0;
        1:       sat = 16'd32768;
        2:       sat = FRAC_IN_W'($urandom_range(32769, 65535));
        3:       sat = FRAC_IN_W'($urandom_range(0, 65535));
        default: sat = FRAC_IN_W'($urandom_range(1, 32767));
      endcase
      case ($urandom_range(15))
        0:       val = '0;
        1:       val = 16'd32768;
        2:       val = FRAC_IN_W'($urandom_range(32769, 65535));
        3:       val = FRAC_IN_W'($urandom_range(0, 65535));
        default: val = FRAC_IN_W'($urandom_range(1, 32767));
      endcase
      send_pixel(hue, sat, val, 1'b0, '0);
    end
    no_idle  = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
